// ===== hdl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_UPDATE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int STAMP_W = 32;
   localparam int CAP_W   = 5;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value_out;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic scan_clear;
      logic scan_step;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic scan_last;
   } dp_sts_type;

endpackage

// ===== hdl/lfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a request, scan all entries, commit, then present result.
// ----------------------------------------------------------------------------
module lfu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lfu_pkg::dp_cmd_type dp_cmd,
   input  lfu_pkg::dp_sts_type dp_sts
);
   import lfu_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      dp_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.load = 1'b1;
               dp_cmd.scan_clear = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            dp_cmd.scan_step = 1'b1;
            if (dp_sts.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            dp_cmd.commit = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("response dropped while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request accepted while busy");
   a_commit_then_resp: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |=> rsp_tvalid)
      else $error("commit not followed by response");
`endif
endmodule

// ===== hdl/lfu_dp.sv =====
// ----------------------------------------------------------------------------
// lfu_dp
// Entry storage, one-entry-per-cycle lookup and victim scan, and write-back.
// ----------------------------------------------------------------------------
module lfu_dp #(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lfu_pkg::req_type     req,
   input  logic [4:0]           capacity,
   input  lfu_pkg::dp_cmd_type  dp_cmd,
   output lfu_pkg::dp_sts_type  dp_sts,
   output lfu_pkg::rsp_type     rsp
);
   import lfu_pkg::*;

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OW = $clog2(MAX_ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   logic [MAX_ENTRIES-1:0]  valid_ff;
   logic [KEY_W-1:0]        key_mem   [MAX_ENTRIES];
   logic [VAL_W-1:0]        val_mem   [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]   cnt_mem   [MAX_ENTRIES];
   logic [STAMP_W-1:0]      stamp_mem [MAX_ENTRIES];

   logic [STAMP_W-1:0]      stamp_ff;
   logic [OW-1:0]           occ_ff;
   req_type                 req_ff;
   rsp_type                 rsp_ff;
   logic [IW-1:0]           idx_ff;
   logic                    hit_ff;
   logic [IW-1:0]           hit_idx_ff;
   logic                    vic_ok_ff;
   logic [IW-1:0]           vic_idx_ff;
   logic [COUNT_BITS-1:0]   vic_cnt_ff;
   logic [STAMP_W-1:0]      vic_stamp_ff;
   logic                    free_ok_ff;
   logic [IW-1:0]           free_idx_ff;

   logic [KEY_W-1:0]        cur_key;
   logic [COUNT_BITS-1:0]   cur_cnt;
   logic [STAMP_W-1:0]      cur_stamp;
   logic                    cur_valid;
   logic [OW-1:0]           cap_eff;

   assign cur_valid = valid_ff[idx_ff];
   assign cur_key   = key_mem[idx_ff];
   assign cur_cnt   = cnt_mem[idx_ff];
   assign cur_stamp = stamp_mem[idx_ff];
   assign dp_sts.scan_last = (idx_ff == IW'(MAX_ENTRIES - 1));
   assign rsp = rsp_ff;

   always_comb begin
      if (capacity == 5'd0) begin
         cap_eff = OW'(1);
      end else if (32'(capacity) > MAX_ENTRIES) begin
         cap_eff = OW'(MAX_ENTRIES);
      end else begin
         cap_eff = OW'(capacity);
      end
   end

   logic                    do_touch, do_insert, do_evict;
   logic [IW-1:0]           tgt;
   logic                    cmd_ok;

   always_comb begin
      cmd_ok    = (req_ff.cmd == CMD_INSERT) || (req_ff.cmd == CMD_UPDATE) ||
                  (req_ff.cmd == CMD_GET);
      do_touch  = cmd_ok && hit_ff;
      do_evict  = (req_ff.cmd == CMD_INSERT) && !hit_ff && (occ_ff >= cap_eff) && vic_ok_ff;
      do_insert = (req_ff.cmd == CMD_INSERT) && !hit_ff && (do_evict || free_ok_ff);
      tgt       = do_evict ? vic_idx_ff : free_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         stamp_ff <= '0;
         occ_ff   <= '0;
      end else if (dp_cmd.commit) begin
         if (do_touch || do_insert) begin
            stamp_ff <= stamp_ff + 1'b1;
         end
         if (do_insert && !do_evict) begin
            occ_ff <= occ_ff + 1'b1;
         end
         if (do_insert) begin
            valid_ff[tgt] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         req_ff <= req;
      end
      if (dp_cmd.scan_clear) begin
         idx_ff     <= '0;
         hit_ff     <= 1'b0;
         vic_ok_ff  <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if (dp_cmd.scan_step) begin
         if (!dp_sts.scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cur_valid && cur_key == req_ff.key && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
         end
         if (!cur_valid && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (cur_valid && (!vic_ok_ff || cur_cnt < vic_cnt_ff ||
             (cur_cnt == vic_cnt_ff && cur_stamp < vic_stamp_ff))) begin
            vic_ok_ff    <= 1'b1;
            vic_idx_ff   <= idx_ff;
            vic_cnt_ff   <= cur_cnt;
            vic_stamp_ff <= cur_stamp;
         end
      end
      if (dp_cmd.commit) begin
         if (do_touch) begin
            if (req_ff.cmd == CMD_GET) begin
               rsp_ff <= {1'b1, val_mem[hit_idx_ff], 1'b0, {KEY_W{1'b0}}};
            end else begin
               rsp_ff <= {1'b1, {VAL_W{1'b0}}, 1'b0, {KEY_W{1'b0}}};
               val_mem[hit_idx_ff] <= req_ff.value_in;
            end
            if (cnt_mem[hit_idx_ff] != CNT_MAX) begin
               cnt_mem[hit_idx_ff] <= cnt_mem[hit_idx_ff] + 1'b1;
            end
            stamp_mem[hit_idx_ff] <= stamp_ff;
         end else if (do_insert) begin
            if (do_evict) begin
               rsp_ff <= {1'b0, {VAL_W{1'b0}}, 1'b1, key_mem[vic_idx_ff]};
            end else begin
               rsp_ff <= '0;
            end
            key_mem[tgt]   <= req_ff.key;
            val_mem[tgt]   <= req_ff.value_in;
            cnt_mem[tgt]   <= COUNT_BITS'(1);
            stamp_mem[tgt] <= stamp_ff;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= MAX_ENTRIES)
      else $error("occupancy above table size");
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(valid_ff))
      else $error("occupancy out of step with valid bits");
   a_evict_insert: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit && do_evict) |-> do_insert)
      else $error("eviction without insert");
`endif
endmodule

// ===== hdl/lfu_cache_table.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key/value table with LFU replacement and least-recently-touched tie break.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         tdata: cmd, key, value_in
// rsp      out        tdata: hit, value_out, evicted, evicted_key
// csr      in         capacity_in_use
//
// Each request is captured, then every entry is scanned in turn through the
// shared compare unit, and a commit step then performs the write-back.
// A new request is taken once the previous response has been delivered.
// Reset clears valid bits, occupancy and the stamp counter.
// ----------------------------------------------------------------------------
module lfu_cache_table #(
   parameter int MAX_ENTRIES = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // cmd[1:0], key[33:2], value_in[65:34]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // hit[0], value_out[32:1], evicted[33],
                                     // evicted_key[65:34]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);
   import lfu_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   req_type          req;
   rsp_type          rsp;
   dp_cmd_type       dp_cmd;
   dp_sts_type       dp_sts;

   assign csr_ready = 1'b1;
   assign req.cmd      = req_tdata[1:0];
   assign req.key      = req_tdata[33:2];
   assign req.value_in = req_tdata[65:34];
   assign rsp_tdata = {6'd0, rsp.evicted_key, rsp.evicted, rsp.value_out, rsp.hit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(16);
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   lfu_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .dp_cmd(dp_cmd), .dp_sts(dp_sts)
   );

   lfu_dp #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock(clock), .reset(reset), .req(req), .capacity(cap_ff),
      .dp_cmd(dp_cmd), .dp_sts(dp_sts), .rsp(rsp)
   );
endmodule
